@@ sv/rvxs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rvxs_pkg;

   localparam int XLEN       = 64;
   localparam int ILEN       = 32;
   localparam int NUM_REGS   = 32;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);
   localparam int HALF_W     = XLEN / 2;

   // Stream payload layout
   localparam int REQ_DATA_W = ILEN + XLEN;               // inst, load_data
   localparam int REQ_USER_W = 3;                         // op
   localparam int RSP_FLD_W  = 3 * XLEN + REG_IDX_W;
   localparam int RSP_DATA_W = ((RSP_FLD_W + 7) / 8) * 8; // byte padded
   localparam int RSP_USER_W = 3;                         // mem_valid, mem_write, wb_valid

   // Stack top placed in x2 at reset
   localparam logic [XLEN-1:0] RAM_BASE  = 64'h0000_0000_8000_0000;
   localparam logic [XLEN-1:0] RAM_SIZE  = 64'h0000_0000_0800_0000;
   localparam logic [XLEN-1:0] STACK_TOP = RAM_BASE + RAM_SIZE;
   localparam logic [REG_IDX_W-1:0] SP_IDX = REG_IDX_W'(2);
   localparam logic [REG_IDX_W-1:0] ZERO_IDX = '0;

   typedef enum logic [2:0] {
      OP_LUI  = 3'd0,
      OP_ADDI = 3'd1,
      OP_LD   = 3'd2,
      OP_SD   = 3'd3,
      OP_ADD  = 3'd4,
      OP_SUB  = 3'd5,
      OP_MUL  = 3'd6,
      OP_LRET = 3'd7
   } rvxs_op_type;

   typedef struct packed {
      logic                 mem_valid;
      logic                 mem_write;
      logic [XLEN-1:0]      mem_addr;
      logic [XLEN-1:0]      store_data;
      logic                 wb_valid;
      logic [REG_IDX_W-1:0] wb_index;
      logic [XLEN-1:0]      wb_value;
   } rvxs_res_type;

   function automatic logic [REG_IDX_W-1:0] inst_rd(input logic [ILEN-1:0] w);
      return w[11:7];
   endfunction

   function automatic logic [REG_IDX_W-1:0] inst_rs1(input logic [ILEN-1:0] w);
      return w[19:15];
   endfunction

   function automatic logic [REG_IDX_W-1:0] inst_rs2(input logic [ILEN-1:0] w);
      return w[24:20];
   endfunction

   function automatic logic [XLEN-1:0] imm_i(input logic [ILEN-1:0] w);
      return {{(XLEN-12){w[31]}}, w[31:20]};
   endfunction

   function automatic logic [XLEN-1:0] imm_s(input logic [ILEN-1:0] w);
      return {{(XLEN-12){w[31]}}, w[31:25], w[11:7]};
   endfunction

   function automatic logic reads_rs1(input rvxs_op_type op);
      return (op != OP_LUI) && (op != OP_LRET);
   endfunction

   function automatic logic reads_rs2(input rvxs_op_type op);
      return (op == OP_SD) || (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL);
   endfunction

   function automatic logic [XLEN-1:0] rf_reset_value(input logic [REG_IDX_W-1:0] idx);
      return (idx == SP_IDX) ? STACK_TOP : '0;
   endfunction

endpackage

`default_nettype wire

@@ sv/rv64_integer_execute_subset.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Results pass stage 1, stage 2 and the output register before they are valid on rsp.
// Throughput: one transaction per cycle when rsp_tready does not stall; an item that reads
// the destination of a MUL directly ahead waits while the product is summed in stage 2.
// Register file: 32x64 memory, two registered read ports, one write port.
// Reset (synchronous): empties the pipe, clears the pending load destination and
// the register-file written flags, so all registers but x2 read zero and x2 the stack top.

module rv64_integer_execute_subset (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rvxs_pkg::REQ_DATA_W-1:0] req_tdata,  // inst[31:0], load_data[95:32]
   input  logic [rvxs_pkg::REQ_USER_W-1:0] req_tuser,  // op[2:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rvxs_pkg::RSP_DATA_W-1:0] rsp_tdata,  // mem_addr, store_data, wb_index,
                                                       // wb_value, zero pad
   output logic [rvxs_pkg::RSP_USER_W-1:0] rsp_tuser   // mem_valid, mem_write, wb_valid
);
   import rvxs_pkg::*;

   // Stage 1: operand read (memory data arrives) and execute
   logic                 s1_vld_ff, s1_vld_in;
   rvxs_op_type          s1_op_ff;
   logic [ILEN-1:0]      s1_inst_ff;
   logic [XLEN-1:0]      s1_data_ff;
   // Stage 2: product sum and register-file write
   logic                 s2_vld_ff, s2_vld_in;
   // Output register
   logic                 rsp_vld_ff, rsp_vld_in;
   rvxs_res_type         rsp_res_ff;
   // Bypass of the write done at the last edge (memory returns old data then)
   logic                 byp_vld_ff, byp_vld_in;
   logic [REG_IDX_W-1:0] byp_idx_ff;
   logic [XLEN-1:0]      byp_val_ff;

   logic                 req_acc, out_free, s2_go, s2_free, s1_go, s1_hold, hazard;
   logic [ILEN-1:0]      req_inst;
   logic [REG_IDX_W-1:0] s1_rs1, s1_rs2, rd_addr_a, rd_addr_b;
   logic [XLEN-1:0]      rf_a, rf_b, src_a, src_b;
   rvxs_res_type         s2_res, fin_res;
   logic                 s2_is_mul, wr_en;

   assign req_inst = req_tdata[ILEN-1:0];
   assign s1_rs1   = inst_rs1(s1_inst_ff);
   assign s1_rs2   = inst_rs2(s1_inst_ff);

   // Handshake chain: output register -> stage 2 -> stage 1 -> req_tready
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign s2_go    = s2_vld_ff && out_free;
   assign s2_free  = !s2_vld_ff || out_free;

   // Product not ready until stage 2 ends: hold a dependent item until it leaves stage 2
   assign hazard = s1_vld_ff && s2_vld_ff && s2_is_mul &&
                   ((reads_rs1(s1_op_ff) && (s1_rs1 == s2_res.wb_index)) ||
                    (reads_rs2(s1_op_ff) && (s1_rs2 == s2_res.wb_index)));

   assign s1_go      = s1_vld_ff && !hazard && s2_free;
   assign s1_hold    = s1_vld_ff && !s1_go;
   assign req_tready = !s1_vld_ff || s1_go;
   assign req_acc    = req_tvalid && req_tready;

   // A held item re-reads its sources each cycle so the bypass stays one write deep
   assign rd_addr_a = s1_hold ? s1_rs1 : inst_rs1(req_inst);
   assign rd_addr_b = s1_hold ? s1_rs2 : inst_rs2(req_inst);

   assign wr_en = s2_go && fin_res.wb_valid;

   rvxs_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr_en     (wr_en),
      .wr_addr   (fin_res.wb_index),
      .wr_data   (fin_res.wb_value),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   // Forwarding: stage 2 is newer than the bypassed write
   always_comb begin
      priority if (s1_rs1 == ZERO_IDX) begin
         src_a = '0;
      end else if (s2_vld_ff && s2_res.wb_valid && (s2_res.wb_index == s1_rs1)) begin
         src_a = s2_res.wb_value;
      end else if (byp_vld_ff && (byp_idx_ff == s1_rs1)) begin
         src_a = byp_val_ff;
      end else begin
         src_a = rf_a;
      end
   end

   always_comb begin
      priority if (s1_rs2 == ZERO_IDX) begin
         src_b = '0;
      end else if (s2_vld_ff && s2_res.wb_valid && (s2_res.wb_index == s1_rs2)) begin
         src_b = s2_res.wb_value;
      end else if (byp_vld_ff && (byp_idx_ff == s1_rs2)) begin
         src_b = byp_val_ff;
      end else begin
         src_b = rf_b;
      end
   end

   rvxs_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_go),
      .op        (s1_op_ff),
      .inst      (s1_inst_ff),
      .load_data (s1_data_ff),
      .src_a     (src_a),
      .src_b     (src_b),
      .s2_res    (s2_res),
      .s2_is_mul (s2_is_mul),
      .fin_res   (fin_res)
   );

   assign s1_vld_in  = req_acc ? 1'b1 : (s1_go ? 1'b0 : s1_vld_ff);
   assign s2_vld_in  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_vld_ff);
   assign rsp_vld_in = s2_go ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);
   assign byp_vld_in = wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         byp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         byp_vld_ff <= byp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_op_ff   <= rvxs_op_type'(req_tuser);
         s1_inst_ff <= req_inst;
         s1_data_ff <= req_tdata[REQ_DATA_W-1:ILEN];
      end
      if (s2_go) begin
         rsp_res_ff <= fin_res;
      end
      byp_idx_ff <= fin_res.wb_index;
      byp_val_ff <= fin_res.wb_value;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_FLD_W){1'b0}}, rsp_res_ff.wb_value,
                        rsp_res_ff.wb_index, rsp_res_ff.store_data, rsp_res_ff.mem_addr};
   assign rsp_tuser  = {rsp_res_ff.wb_valid, rsp_res_ff.mem_write, rsp_res_ff.mem_valid};

   // x0 is never reported as written
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (fin_res.wb_index != ZERO_IDX))
      else $error("write to x0");

   // A stage-1 item never advances past an unfinished product it depends on
   a_mul_interlock: assert property (@(posedge clock) disable iff (reset)
      hazard |=> (s1_vld_ff && !$stable(s2_vld_ff && s2_is_mul) ) || !s1_vld_ff || s2_vld_ff)
      else $error("dependent item passed a pending product");

   // A memory access (load or store) and a writeback never come from the same transaction
   a_mem_wb_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_res_ff.mem_valid && rsp_res_ff.wb_valid))
      else $error("memory access and writeback in one transaction");

   // Held stage-1 item keeps its instruction word
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_hold |=> $stable(s1_inst_ff) && s1_vld_ff)
      else $error("stage 1 lost a held item");

endmodule

`default_nettype wire

@@ sv/rvxs_regfile.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rvxs_regfile (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rvxs_pkg::REG_IDX_W-1:0] rd_addr_a,
   input  logic [rvxs_pkg::REG_IDX_W-1:0] rd_addr_b,
   input  logic                           wr_en,
   input  logic [rvxs_pkg::REG_IDX_W-1:0] wr_addr,
   input  logic [rvxs_pkg::XLEN-1:0]      wr_data,
   output logic [rvxs_pkg::XLEN-1:0]      rd_data_a,
   output logic [rvxs_pkg::XLEN-1:0]      rd_data_b
);
   import rvxs_pkg::*;

   logic [XLEN-1:0]      mem_ff [NUM_REGS];
   logic [NUM_REGS-1:0]  written_ff;
   logic [XLEN-1:0]      data_a_ff, data_b_ff;
   logic                 vld_a_ff, vld_b_ff;
   logic [REG_IDX_W-1:0] idx_a_ff, idx_b_ff;

   // Written flags: an entry never written reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   // Two registered read ports, one write port; read returns old data on collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      data_a_ff <= mem_ff[rd_addr_a];
      data_b_ff <= mem_ff[rd_addr_b];
      vld_a_ff  <= written_ff[rd_addr_a];
      vld_b_ff  <= written_ff[rd_addr_b];
      idx_a_ff  <= rd_addr_a;
      idx_b_ff  <= rd_addr_b;
   end

   assign rd_data_a = vld_a_ff ? data_a_ff : rf_reset_value(idx_a_ff);
   assign rd_data_b = vld_b_ff ? data_b_ff : rf_reset_value(idx_b_ff);

endmodule

`default_nettype wire

@@ sv/rvxs_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rvxs_exec (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  rvxs_pkg::rvxs_op_type        op,
   input  logic [rvxs_pkg::ILEN-1:0]    inst,
   input  logic [rvxs_pkg::XLEN-1:0]    load_data,
   input  logic [rvxs_pkg::XLEN-1:0]    src_a,
   input  logic [rvxs_pkg::XLEN-1:0]    src_b,
   output rvxs_pkg::rvxs_res_type       s2_res,
   output logic                         s2_is_mul,
   output rvxs_pkg::rvxs_res_type       fin_res
);
   import rvxs_pkg::*;

   rvxs_res_type         res_ff, res_in;
   logic                 is_mul_ff, is_mul_in;
   logic [REG_IDX_W-1:0] pend_ff, pend_in;
   logic [XLEN-1:0]      p_ll_ff, p_ll_in;
   logic [HALF_W-1:0]    p_lh_ff, p_lh_in, p_hl_ff, p_hl_in;
   logic [XLEN-1:0]      imm_sel, addr_sum;
   logic                 wr;
   logic [REG_IDX_W-1:0] dest;
   logic [XLEN-1:0]      val;

   assign imm_sel  = (op == OP_SD) ? imm_s(inst) : imm_i(inst);
   assign addr_sum = src_a + imm_sel;

   // Low 64 bits of a*b from three 32x32 products; summed in stage 2
   assign p_ll_in = XLEN'(src_a[HALF_W-1:0]) * XLEN'(src_b[HALF_W-1:0]);
   assign p_lh_in = src_a[HALF_W-1:0] * src_b[XLEN-1:HALF_W];
   assign p_hl_in = src_a[XLEN-1:HALF_W] * src_b[HALF_W-1:0];

   always_comb begin
      res_in  = '0;
      wr      = 1'b0;
      dest    = inst_rd(inst);
      val     = '0;
      pend_in = pend_ff;
      unique case (op)
         OP_LUI:  begin
            wr  = 1'b1;
            val = {{(XLEN-ILEN){inst[31]}}, inst[31:12], 12'b0};
         end
         OP_ADDI: begin
            wr  = 1'b1;
            val = addr_sum;
         end
         OP_LD:   begin
            res_in.mem_valid = 1'b1;
            res_in.mem_addr  = addr_sum;
            pend_in          = inst_rd(inst);
         end
         OP_SD:   begin
            res_in.mem_valid  = 1'b1;
            res_in.mem_write  = 1'b1;
            res_in.mem_addr   = addr_sum;
            res_in.store_data = src_b;
         end
         OP_ADD:  begin
            wr  = 1'b1;
            val = src_a + src_b;
         end
         OP_SUB:  begin
            wr  = 1'b1;
            val = src_a - src_b;
         end
         OP_MUL:  begin
            wr = 1'b1;
         end
         OP_LRET: begin
            wr   = 1'b1;
            dest = pend_ff;
            val  = load_data;
         end
         default: begin
            wr = 1'b0;
         end
      endcase
      // x0 writes are dropped
      if (wr && (dest != ZERO_IDX)) begin
         res_in.wb_valid = 1'b1;
         res_in.wb_index = dest;
         res_in.wb_value = val;
      end
      is_mul_in = (op == OP_MUL) && res_in.wb_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= ZERO_IDX;
      end else if (load) begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff    <= res_in;
         is_mul_ff <= is_mul_in;
         p_ll_ff   <= p_ll_in;
         p_lh_ff   <= p_lh_in;
         p_hl_ff   <= p_hl_in;
      end
   end

   always_comb begin
      fin_res = res_ff;
      if (is_mul_ff) begin
         fin_res.wb_value = p_ll_ff + {p_lh_ff + p_hl_ff, {HALF_W{1'b0}}};
      end
   end

   assign s2_res    = res_ff;
   assign s2_is_mul = is_mul_ff;

endmodule

`default_nettype wire
